// ===== rtl/ps_pack_header_scr_indexer_unit_defines.svh =====
// assertion macros shared by the pack header indexer rtl
// expects signals clk and rst in the scope where a macro is used
`ifndef PS_PACK_HEADER_SCR_INDEXER_UNIT_DEFINES_SVH
`define PS_PACK_HEADER_SCR_INDEXER_UNIT_DEFINES_SVH

// same-cycle implication, checked outside reset
`define PSHDR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define PSHDR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/pshdr_pkg.sv =====
// types and constants for the program stream pack header indexer
// no dependencies
package pshdr_pkg;

  localparam int WIN_LEN     = 14;
  localparam int PACK_OFF_W  = 48;
  localparam int SCR_W       = 33;
  localparam int SCR_MS_W    = 27;
  localparam int HALF_W      = 32;

  localparam logic [7:0] START_B0  = 8'h00;
  localparam logic [7:0] START_B1  = 8'h00;
  localparam logic [7:0] START_B2  = 8'h01;
  localparam logic [7:0] PACK_CODE = 8'hBA;

  // scr / 90 is done as (scr >> 1) / 45 with a reciprocal multiply
  localparam int              DIV_HALF   = 45;
  localparam int              RECIP_SH   = 37;
  localparam logic [HALF_W-1:0] RECIP_MUL = 32'd3054198966; // floor(2^37 / 45)

  localparam logic [SCR_MS_W-1:0] SCR_MS_MAX = 27'd95443717;

  typedef struct packed {
    logic [PACK_OFF_W-1:0] offset;
    logic [SCR_W-1:0]      scr_raw;
  } pshdr_entry_t;

endpackage

// ===== rtl/pshdr_ifs.sv =====
// valid/ready channel interfaces for the pack header indexer
// depends on pshdr_pkg
interface pshdr_byte_if;
  import pshdr_pkg::*;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       stream_start;
  modport source(output valid, data_byte, stream_start, input ready);
  modport sink(input valid, data_byte, stream_start, output ready);
endinterface

interface pshdr_pack_if;
  import pshdr_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [PACK_OFF_W-1:0] hdr_offset;
  logic [SCR_MS_W-1:0]   scr_ms;
  modport source(output valid, hdr_offset, scr_ms, input ready);
  modport sink(input valid, hdr_offset, scr_ms, output ready);
endinterface

// ===== rtl/pshdr_front.sv =====
// front end: byte window, stream offset counter and start code detection
// depends on pshdr_pkg and pshdr_byte_if
module pshdr_front #(
  parameter int OFFSET_BITS = 48
) (
  input  logic                   clk,
  input  logic                   rst,
  pshdr_byte_if.sink             byte_in,
  input  logic                   q_full,
  output logic                   push,
  output pshdr_pkg::pshdr_entry_t push_entry
);
  import pshdr_pkg::*;

  logic [7:0]             window [WIN_LEN];
  logic [OFFSET_BITS-1:0] count;
  logic                   accept;
  logic                   hit;
  logic [OFFSET_BITS-1:0] hdr_off;
  logic [SCR_W-1:0]       scr;

  assign byte_in.ready = !q_full && !rst;
  assign accept        = byte_in.valid && byte_in.ready;

  // after the shift the oldest four bytes are window[1..4] of today
  assign hit = !byte_in.stream_start &&
               window[1] == START_B0 && window[2] == START_B1 &&
               window[3] == START_B2 && window[4] == PACK_CODE;

  // new count minus window length, i.e. count + 1 - 14
  assign hdr_off = count - OFFSET_BITS'(WIN_LEN - 1);

  assign scr = {window[5][5:3], window[5][1:0], window[6],
                window[7][7:3], window[7][1:0], window[8], window[9][7:3]};

  assign push               = accept && hit;
  assign push_entry.offset  = PACK_OFF_W'(hdr_off);
  assign push_entry.scr_raw = scr;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      for (int i = 0; i < WIN_LEN; i++) window[i] <= '0;
    end else if (accept) begin
      if (byte_in.stream_start) begin
        count <= OFFSET_BITS'(1);
        for (int i = 0; i < WIN_LEN - 1; i++) window[i] <= '0;
      end else begin
        count <= count + OFFSET_BITS'(1);
        for (int i = 0; i < WIN_LEN - 1; i++) window[i] <= window[i+1];
      end
      window[WIN_LEN-1] <= byte_in.data_byte;
    end
  end

endmodule

// ===== rtl/pshdr_fifo.sv =====
// short queue of detected headers between front and back end
// depends on pshdr_pkg and the assertion macro header
module pshdr_fifo #(
  parameter int DEPTH = 4
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  pshdr_pkg::pshdr_entry_t push_entry,
  input  logic                    pop,
  output pshdr_pkg::pshdr_entry_t head,
  output logic                    full,
  output logic                    empty
);
  import pshdr_pkg::*;
  `include "ps_pack_header_scr_indexer_unit_defines.svh"

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  pshdr_entry_t     slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;

  assign full  = fill == CNT_W'(DEPTH);
  assign empty = fill == '0;
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      if (pop)  rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      if (push && !pop)      fill <= fill + CNT_W'(1);
      else if (pop && !push) fill <= fill - CNT_W'(1);
    end
  end

  `PSHDR_ASSERT_NOW(a_no_overflow, push, !full, "header queue written while full")
  `PSHDR_ASSERT_NOW(a_no_underflow, pop, !empty, "header queue read while empty")
  `PSHDR_ASSERT_NOW(a_fill_range, 1'b1, fill <= CNT_W'(DEPTH), "header queue fill out of range")

endmodule

// ===== rtl/pshdr_back.sv =====
// back end: scr base to milliseconds (reciprocal multiply) and output register
// depends on pshdr_pkg, pshdr_pack_if and the assertion macro header
module pshdr_back (
  input  logic                    clk,
  input  logic                    rst,
  input  pshdr_pkg::pshdr_entry_t head,
  input  logic                    empty,
  output logic                    pop,
  pshdr_pack_if.source            pack_out
);
  import pshdr_pkg::*;
  `include "ps_pack_header_scr_indexer_unit_defines.svh"

  logic                    st1_valid;
  logic [PACK_OFF_W-1:0]   st1_off;
  logic [HALF_W-1:0]       st1_half;
  logic [2*HALF_W-1:0]     st1_prod;
  logic                    out_valid;
  logic [PACK_OFF_W-1:0]   out_off;
  logic [SCR_MS_W-1:0]     out_ms;
  logic                    out_load;
  logic                    st1_free;
  logic [SCR_MS_W-1:0]     q_est;
  logic [HALF_W-1:0]       rem;
  logic [SCR_MS_W-1:0]     q_fix;

  assign out_load = !out_valid || pack_out.ready;
  assign st1_free = !st1_valid || out_load;
  assign pop      = !empty && st1_free;

  // estimate is exact or one low, fixed by a single remainder compare
  assign q_est = SCR_MS_W'(st1_prod >> RECIP_SH);
  assign rem   = st1_half - HALF_W'(q_est) * HALF_W'(DIV_HALF);
  assign q_fix = (rem >= HALF_W'(DIV_HALF)) ? q_est + SCR_MS_W'(1) : q_est;

  always_ff @(posedge clk) begin
    if (rst) begin
      st1_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (st1_free) st1_valid <= pop;
      if (out_load) out_valid <= st1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      st1_off  <= head.offset;
      st1_half <= head.scr_raw[SCR_W-1:1];
      st1_prod <= head.scr_raw[SCR_W-1:1] * RECIP_MUL;
    end
    if (out_load && st1_valid) begin
      out_off <= st1_off;
      out_ms  <= q_fix;
    end
  end

  assign pack_out.valid      = out_valid;
  assign pack_out.hdr_offset = out_off;
  assign pack_out.scr_ms     = out_ms;

  `PSHDR_ASSERT_NEXT(a_st1_hold, st1_valid && !out_load, st1_valid,
                     "divide stage lost a header while stalled")
  `PSHDR_ASSERT_NEXT(a_out_hold, out_valid && !pack_out.ready, out_valid,
                     "result dropped while the receiver stalled")
  `PSHDR_ASSERT_NOW(a_ms_range, out_valid, out_ms <= SCR_MS_MAX, "scr_ms beyond 33-bit range")

endmodule

// ===== rtl/ps_pack_header_scr_indexer_unit.sv =====
// MPEG-2 program stream pack header indexer, top level
// depends on pshdr_pkg, pshdr_ifs, pshdr_front, pshdr_fifo, pshdr_back
//
// byte_in carries the program stream one byte per transaction; stream_start
// on a byte restarts the offset counter and clears the 14-byte window, that
// byte then being offset zero. pack_out carries one transaction per pack
// header 00 00 01 BA found: its stream offset (low 48 bits) and the SCR base
// divided by 90 (milliseconds). A header is reported when the tenth byte
// after its start code is taken; headers closer than that to the end of a
// stream are not reported.
// throughput: one byte per clock while the queue is not full. After the edge
// that takes that tenth byte, the result goes through the queue read and
// the one-stage reciprocal multiply ahead of the output register.
// when pack_out stalls, headers wait in a QUEUE_DEPTH-entry queue and bytes
// keep flowing; byte_in.ready drops only once that queue is full.
// reset (rst, synchronous) empties the queue and pipeline, clears the window
// and the counter; byte_in.ready is low while rst is high.
module ps_pack_header_scr_indexer_unit #(
  parameter int OFFSET_BITS = 48,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst,
  pshdr_byte_if.sink   byte_in,
  pshdr_pack_if.source pack_out
);
  import pshdr_pkg::*;

  logic         push;
  pshdr_entry_t push_entry;
  logic         pop;
  pshdr_entry_t head;
  logic         q_full;
  logic         q_empty;

  pshdr_front #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .byte_in   (byte_in),
    .q_full    (q_full),
    .push      (push),
    .push_entry(push_entry)
  );

  pshdr_fifo #(
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_entry(push_entry),
    .pop       (pop),
    .head      (head),
    .full      (q_full),
    .empty     (q_empty)
  );

  pshdr_back u_back (
    .clk     (clk),
    .rst     (rst),
    .head    (head),
    .empty   (q_empty),
    .pop     (pop),
    .pack_out(pack_out)
  );

endmodule

// ===== test/pshdr_pack_checker.sv =====
// pack header checker: follows accepted bytes, predicts each pack header transaction
// and compares what leaves pack_out in order, field by field
// depends on pshdr_pkg and pshdr_ifs
`timescale 1ns / 100ps
module pshdr_pack_checker
  import pshdr_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  pshdr_byte_if byte_mon,
  pshdr_pack_if pack_mon,
  output int    pending,
  output int    mismatches
);

  localparam int SCR_TICKS_PER_MS = 90;

  typedef struct packed {
    logic [PACK_OFF_W-1:0] offset;
    logic [SCR_MS_W-1:0]   ms;
  } pack_rec_t;

  logic [7:0]            win [WIN_LEN];
  logic [PACK_OFF_W-1:0] byte_cnt;
  pack_rec_t             due_packs [$];

  task automatic report_mismatch(input string msg);
    $display("%0t pack_out mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  function automatic logic [SCR_W-1:0] scr_value_of(input logic [7:0] b0, b1, b2, b3, b4);
    // marker bits are skipped, not checked
    return {b0[5:3], b0[1:0], b1, b2[7:3], b2[1:0], b3, b4[7:3]};
  endfunction

  task automatic shift_stream_byte(input logic [7:0] d, input logic restart);
    logic [SCR_W-1:0] scr;
    pack_rec_t        rec;
    if (restart) begin
      foreach (win[i]) win[i] = '0;
      byte_cnt = '0;
    end
    for (int i = 0; i < WIN_LEN - 1; i++) win[i] = win[i + 1];
    win[WIN_LEN - 1] = d;
    byte_cnt = byte_cnt + 1'b1;
    if (win[0] == START_B0 && win[1] == START_B1 && win[2] == START_B2 &&
        win[3] == PACK_CODE) begin
      scr = scr_value_of(win[4], win[5], win[6], win[7], win[8]);
      // offset wraps when the start code partly sits in the cleared window
      rec.offset = byte_cnt - PACK_OFF_W'(WIN_LEN);
      rec.ms     = SCR_MS_W'(scr / SCR_W'(SCR_TICKS_PER_MS));
      due_packs.insert(due_packs.size(), rec);
    end
  endtask

  task automatic check_pack(input logic [PACK_OFF_W-1:0] off, input logic [SCR_MS_W-1:0] ms);
    pack_rec_t want;
    if (due_packs.size() == 0) begin
      report_mismatch($sformatf("no header due, got offset %0d scr_ms %0d", off, ms));
    end else begin
      want = due_packs.pop_front();
      if (off !== want.offset)
        report_mismatch($sformatf("hdr_offset %0d, want %0d", off, want.offset));
      if (ms !== want.ms)
        report_mismatch($sformatf("scr_ms %0d, want %0d (offset %0d)", ms, want.ms, want.offset));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      foreach (win[i]) win[i] = '0;
      byte_cnt = '0;
      due_packs.delete();
      mismatches = 0;
    end else begin
      if (byte_mon.valid && byte_mon.ready)
        shift_stream_byte(byte_mon.data_byte, byte_mon.stream_start);
      if (pack_mon.valid && pack_mon.ready)
        check_pack(pack_mon.hdr_offset, pack_mon.scr_ms);
    end
    pending <= due_packs.size();
  end

endmodule

// ===== test/ps_pack_header_scr_indexer_unit_tb.sv =====
// testbench top for the pack header indexer: drives program stream bytes with random
// gaps and back-pressure on the results, verdict from pshdr_pack_checker
// depends on pshdr_pkg, pshdr_ifs, ps_pack_header_scr_indexer_unit, pshdr_pack_checker
`timescale 1ns / 100ps
module ps_pack_header_scr_indexer_unit_tb;
  import pshdr_pkg::*;

  localparam int RANDOM_BYTES     = 1700;
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int SETTLE_CYCLES    = 16;

  typedef enum int {SCR_RANDOM, SCR_ALL_ONES, SCR_ALL_ZERO} scr_fill_t;

  logic clk;
  logic rst;
  int   pending;
  int   mismatches;

  pshdr_byte_if byte_ch ();
  pshdr_pack_if pack_ch ();

  ps_pack_header_scr_indexer_unit DUT (
    .clk(clk),
    .rst(rst),
    .byte_in(byte_ch),
    .pack_out(pack_ch)
  );

  pshdr_pack_checker u_pack_checker (
    .clk(clk),
    .rst(rst),
    .byte_mon(byte_ch),
    .pack_mon(pack_ch),
    .pending(pending),
    .mismatches(mismatches)
  );

  logic [7:0] seg [$];
  bit         restart_next;
  bit         tx_fast;
  bit         rx_fast;
  bit         hold_req;
  int         sent;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("tb: failure");
    $finish;
  end

  task automatic send_byte(input logic [7:0] d, input logic restart);
    int gap;
    gap = tx_fast ? 0 : $urandom_range(0, 13);
    if (gap != 0) begin
      byte_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    byte_ch.valid        <= 1'b1;
    byte_ch.data_byte    <= d;
    byte_ch.stream_start <= restart;
    do @(posedge clk); while (!byte_ch.ready);
    sent++;
  endtask

  task automatic flush_seg();
    foreach (seg[i]) begin
      send_byte(seg[i], restart_next);
      restart_next = 1'b0;
    end
    seg.delete();
  endtask

  // lead is how many of the two leading zero bytes are sent
  task automatic push_header(input int lead, input int tail, input scr_fill_t fill);
    if (lead > 1) seg.insert(seg.size(), START_B0);
    if (lead > 0) seg.insert(seg.size(), START_B1);
    seg.insert(seg.size(), START_B2);
    seg.insert(seg.size(), PACK_CODE);
    for (int i = 0; i < tail; i++) begin
      if (i < 5 && fill == SCR_ALL_ONES) seg.insert(seg.size(), 8'hFF);
      else if (i < 5 && fill == SCR_ALL_ZERO) seg.insert(seg.size(), 8'h00);
      else seg.insert(seg.size(), 8'($urandom));
    end
  endtask

  // noise leans toward start code bytes so near-misses show up often
  task automatic push_noise(input int n);
    int pick;
    repeat (n) begin
      pick = $urandom_range(0, 5);
      if (pick == 0) seg.insert(seg.size(), START_B0);
      else if (pick == 1) seg.insert(seg.size(), START_B2);
      else if (pick == 2) seg.insert(seg.size(), PACK_CODE);
      else seg.insert(seg.size(), 8'($urandom));
    end
  endtask

  function automatic scr_fill_t pick_fill();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return SCR_ALL_ONES;
    if (pick == 1) return SCR_ALL_ZERO;
    return SCR_RANDOM;
  endfunction

  task automatic wait_drained();
    byte_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // result side: random stalls, fast stretches, one long hold on request
  initial begin : result_sink
    int stall;
    pack_ch.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (hold_req) begin
        pack_ch.ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end
      if ($urandom_range(0, 19) == 0) rx_fast = !rx_fast;
      stall = rx_fast ? 0 : $urandom_range(0, 13);
      if (stall != 0) begin
        pack_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      pack_ch.ready <= 1'b1;
      do @(posedge clk); while (!(pack_ch.valid && pack_ch.ready));
    end
  end

  initial begin : stream_source
    int pick;
    int next_drain;
    bit pressed;
    rst                  <= 1'b1;
    byte_ch.valid        <= 1'b0;
    byte_ch.data_byte    <= '0;
    byte_ch.stream_start <= 1'b0;
    restart_next = 1'b0;
    tx_fast      = 1'b0;
    rx_fast      = 1'b0;
    hold_req     = 1'b0;
    sent         = 0;
    pressed      = 1'b0;
    next_drain   = 500;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // header straddling the cleared window after reset, max and zero scr,
    // then a header cut short by a restart in mid-stream
    push_header(0, 5, SCR_ALL_ONES);
    push_header(2, 5, SCR_ALL_ZERO);
    push_header(2, 5, SCR_RANDOM);
    flush_seg();
    restart_next = 1'b1;

    while (sent < RANDOM_BYTES + 25) begin
      tx_fast = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        push_header(2, 10 + $urandom_range(0, 12), pick_fill());
      end else if (pick < 67) begin
        // new stream, sometimes opening on a start code short of its zeros
        restart_next = 1'b1;
        if ($urandom_range(0, 1) == 0) push_header($urandom_range(0, 2), 10, pick_fill());
        else push_noise($urandom_range(1, 6));
      end else if (pick < 77) begin
        // header too close to the end of its stream
        push_header(2, $urandom_range(0, 9), pick_fill());
        flush_seg();
        restart_next = 1'b1;
      end else begin
        push_noise($urandom_range(1, 20));
      end
      flush_seg();

      if (!pressed && sent > 800) begin
        // back-to-back headers against a stalled result side
        pressed  = 1'b1;
        hold_req = 1'b1;
        tx_fast  = 1'b1;
        repeat (30) push_header(2, 10, SCR_RANDOM);
        flush_seg();
        wait_drained();
      end
      if (sent >= next_drain) begin
        wait_drained();
        next_drain += 500;
      end
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
